// ===== hdl/rtm_pkg.sv =====
// Shared types, constants and helpers for the row-times-matrix MAC core.
`default_nettype none

package rtm_pkg;

    localparam int VAL_W       = 32;  // matrix entry and sum width
    localparam int IDX_W       = 3;   // row, column and result column index width
    localparam int CFG_W       = 4;   // configuration register width
    localparam int RESULT_CAP  = 8;   // most results one row can emit
    localparam int DEF_MAX_DIM = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    localparam logic CFG_INNER_LEN = 1'b0;
    localparam logic CFG_OUT_COLS  = 1'b1;

    localparam logic [CFG_W-1:0] INNER_LEN_RST = 4'd8;
    localparam logic [CFG_W-1:0] OUT_COLS_RST  = 4'd8;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN
    } seq_state_t;

    // One column step handed from the sequencer to the MAC pipeline.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] col;
        logic             emit;   // final position of the row: output and clear
        logic             last;   // final column of the row
    } issue_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } pipe_status_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] top);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = 4'd1;
        else if (v > top)
            r = top;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rtm_store.sv =====
// Right-matrix store: one write port, one registered read port.
`default_nettype none

module rtm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [AW-1:0]            waddr,
    input  wire  [rtm_pkg::VAL_W-1:0] wdata,
    input  wire                      re,
    input  wire  [AW-1:0]            raddr,
    output logic [rtm_pkg::VAL_W-1:0] rdata
);
    import rtm_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/rtm_seq.sv =====
// Sequencer: decodes commands, writes loads, sweeps columns for a streamed element.
`default_nettype none

module rtm_seq #(
    parameter int MAX_DIM = rtm_pkg::DEF_MAX_DIM,
    parameter int AW      = 6
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          opcode,
    input  wire  [rtm_pkg::IDX_W-1:0]    row_index,
    input  wire  [rtm_pkg::IDX_W-1:0]    col_index,
    input  wire  [rtm_pkg::CFG_W-1:0]    inner_len,
    input  wire  [rtm_pkg::CFG_W-1:0]    out_cols,
    input  rtm_pkg::pipe_status_t        pipe,
    output logic                         busy,
    output logic                         value_load,
    output logic                         store_we,
    output logic [AW-1:0]                store_waddr,
    output logic [AW-1:0]                store_raddr,
    output rtm_pkg::issue_t              issue
);
    import rtm_pkg::*;

    localparam int DIM_TOP = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;
    localparam int DCW     = 5;   // holds MAX_DIM up to 31

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [CFG_W-1:0]  ncols_reg, ncols_next;
    logic              emit_reg, emit_next;

    logic [CFG_W-1:0]  inner;
    logic [CFG_W-1:0]  ncols;
    logic              accept;
    logic              load_ok;
    logic              col_last;

    assign inner  = clamp_dim(inner_len, CFG_W'(DIM_TOP));
    assign ncols  = clamp_dim(out_cols, CFG_W'(DIM_TOP));
    assign busy   = (state_reg != SEQ_IDLE);
    assign accept = start && !busy;

    assign load_ok = (DCW'(row_index) < DCW'(MAX_DIM)) && (DCW'(col_index) < DCW'(MAX_DIM));
    assign store_we    = accept && (opcode == OP_LOAD) && load_ok;
    assign store_waddr = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
    assign store_raddr = AW'(row_reg) * AW'(MAX_DIM) + AW'(cnt_reg);

    assign col_last = ({1'b0, cnt_reg} == (ncols_reg - 4'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            ncols_reg <= 4'd1;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            ncols_reg <= ncols_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        ncols_next  = ncols_reg;
        emit_next   = emit_reg;
        value_load  = 1'b0;
        issue       = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                // positions past the inner length are taken and dropped
                if (accept && (opcode == OP_STREAM) && ({1'b0, row_index} < inner))
                begin
                    state_next = SEQ_RUN;
                    cnt_next   = '0;
                    row_next   = row_index;
                    ncols_next = ncols;
                    emit_next  = ({1'b0, row_index} == (inner - 4'd1));
                    value_load = 1'b1;
                end
            end
            SEQ_RUN:
            begin
                issue.valid = 1'b1;
                issue.col   = cnt_reg;
                issue.emit  = emit_reg;
                issue.last  = col_last;
                cnt_next    = cnt_reg + 3'd1;
                if (col_last)
                    state_next = SEQ_DRAIN;
            end
            SEQ_DRAIN:
            begin
                // last column retires from stage 2 on the edge that ends this wait
                if (!pipe.s1_valid)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_RUN) |-> ({1'b0, cnt_reg} < ncols_reg))
        else $error("column counter ran past the column count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_RUN && col_last) |=> (state_reg == SEQ_DRAIN))
        else $error("sweep did not drain after the final column");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_DRAIN) |-> !issue.valid)
        else $error("column issued while draining");

endmodule

`default_nettype wire

// ===== hdl/rtm_mac.sv =====
// Shared multiply-accumulate unit with the column sums and the result register.
`default_nettype none

module rtm_mac #(
    parameter int MAX_DIM = rtm_pkg::DEF_MAX_DIM
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          value_load,
    input  wire  [rtm_pkg::VAL_W-1:0]    value,
    input  rtm_pkg::issue_t              issue,
    input  wire  [rtm_pkg::VAL_W-1:0]    rdata,
    output rtm_pkg::pipe_status_t        pipe,
    output logic                         result_strobe,
    output logic [rtm_pkg::VAL_W-1:0]    dot_value,
    output logic [rtm_pkg::IDX_W-1:0]    out_col,
    output logic                         last
);
    import rtm_pkg::*;

    localparam int DIM_TOP = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;
    localparam int SUM_IW  = (DIM_TOP > 1) ? $clog2(DIM_TOP) : 1;

    issue_t            s1_reg;
    issue_t            s2_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  prod_reg;
    logic [VAL_W-1:0]  prod_next;
    logic [VAL_W-1:0]  sum_next;
    logic [VAL_W-1:0]  sums_reg [DIM_TOP];
    logic [SUM_IW-1:0] sum_idx;

    logic              strobe_reg;
    logic [VAL_W-1:0]  dot_value_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic              last_reg;

    // low word of the product is the same for signed and unsigned operands
    assign prod_next = value_reg * rdata;
    assign sum_idx   = s2_reg.col[SUM_IW-1:0];
    assign sum_next  = sums_reg[sum_idx] + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            s2_reg     <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < DIM_TOP; i++)
                sums_reg[i] <= '0;
        end
        else
        begin
            s1_reg     <= issue;
            s2_reg     <= s1_reg;
            strobe_reg <= s2_reg.valid && s2_reg.emit;
            if (s2_reg.valid && s2_reg.emit && s2_reg.last)
            begin
                // row done: every sum restarts, also columns past the count in use
                for (int i = 0; i < DIM_TOP; i++)
                    sums_reg[i] <= '0;
            end
            else if (s2_reg.valid)
                sums_reg[sum_idx] <= s2_reg.emit ? '0 : sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_load)
            value_reg <= value;
        prod_reg      <= prod_next;
        dot_value_reg <= sum_next;
        out_col_reg   <= s2_reg.col;
        last_reg      <= s2_reg.last;
    end

    assign pipe.s1_valid = s1_reg.valid;
    assign pipe.s2_valid = s2_reg.valid;
    assign result_strobe = strobe_reg;
    assign dot_value     = dot_value_reg;
    assign out_col       = out_col_reg;
    assign last          = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && s2_reg.emit) |=> (sums_reg[$past(sum_idx)] == '0))
        else $error("column sum not cleared after its result");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid |=> (s2_reg.col == $past(s1_reg.col)))
        else $error("column lost between MAC stages");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && !s2_reg.last) |-> s1_reg.valid)
        else $error("gap inside a column sweep");

endmodule

`default_nettype wire

// ===== hdl/row_times_matrix_mac_core.sv =====
// Top level of the row-times-matrix MAC core: config registers and block wiring.
`default_nettype none

// Integer matrix product engine. Load the right-hand matrix with opcode 0
// (one entry per transfer; a load leaves busy low), then stream left-row
// elements with opcode 1. A streamed element keeps busy high while one
// shared 32x32 multiply-accumulate sweeps the output columns, one column
// per cycle, behind the store's registered read, and while it drains. When
// the element sits at the final position of the row, the row's results leave
// one per cycle on result_strobe, last set on the final column; the receiver
// cannot stall them. Sums wrap to 32 bits. Elements at positions past the
// inner length are taken and dropped.
// Write inner_len and out_cols only while idle.
module row_times_matrix_mac_core #(
    parameter int MAX_DIM = rtm_pkg::DEF_MAX_DIM
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          opcode,
    input  wire  [rtm_pkg::IDX_W-1:0]    row_index,
    input  wire  [rtm_pkg::IDX_W-1:0]    col_index,
    input  wire  signed [rtm_pkg::VAL_W-1:0] value,
    output logic                         result_strobe,
    output logic signed [rtm_pkg::VAL_W-1:0] dot_value,
    output logic [rtm_pkg::IDX_W-1:0]    out_col,
    output logic                         last,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire  [rtm_pkg::CFG_W-1:0]    cfg_data
);
    import rtm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0] inner_len_reg;
    logic [CFG_W-1:0] out_cols_reg;

    logic             value_load;
    logic             store_we;
    logic [AW-1:0]    store_waddr;
    logic [AW-1:0]    store_raddr;
    logic [VAL_W-1:0] rdata;
    logic [VAL_W-1:0] dot_value_u;
    issue_t           issue;
    pipe_status_t     pipe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_len_reg <= INNER_LEN_RST;
            out_cols_reg  <= OUT_COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INNER_LEN: inner_len_reg <= cfg_data;
                CFG_OUT_COLS:  out_cols_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    rtm_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .row_index   (row_index),
        .col_index   (col_index),
        .inner_len   (inner_len_reg),
        .out_cols    (out_cols_reg),
        .pipe        (pipe),
        .busy        (busy),
        .value_load  (value_load),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_raddr (store_raddr),
        .issue       (issue)
    );

    rtm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (value),
        .re    (issue.valid),
        .raddr (store_raddr),
        .rdata (rdata)
    );

    rtm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .value_load    (value_load),
        .value         (value),
        .issue         (issue),
        .rdata         (rdata),
        .pipe          (pipe),
        .result_strobe (result_strobe),
        .dot_value     (dot_value_u),
        .out_col       (out_col),
        .last          (last)
    );

    assign dot_value = dot_value_u;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> !busy)
        else $error("load transfer left the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without a streamed element in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result after the final column");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=>
            (result_strobe && out_col == 3'($past(out_col) + 3'd1)))
        else $error("result row broken or out of column order");

endmodule

`default_nettype wire

// ===== verif/row_times_matrix_mac_core_tb.sv =====
// Self-checking testbench for row_times_matrix_mac_core: matrix loads, row streams, checked sums.
`default_nettype none

module row_times_matrix_mac_core_tb;

    import rtm_pkg::*;

    typedef struct {
        logic [VAL_W-1:0] dot;
        logic [IDX_W-1:0] col;
        logic             last;
    } dot_entry_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    opcode = OP_LOAD;
    logic [IDX_W-1:0]        row_index = '0;
    logic [IDX_W-1:0]        col_index = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    result_strobe;
    logic signed [VAL_W-1:0] dot_value;
    logic [IDX_W-1:0]        out_col;
    logic                    last;
    logic                    cfg_we = 1'b0;
    logic                    cfg_index = CFG_INNER_LEN;
    logic [CFG_W-1:0]        cfg_data = '0;

    row_times_matrix_mac_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .result_strobe (result_strobe),
        .dot_value     (dot_value),
        .out_col       (out_col),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Predictor state
    logic [VAL_W-1:0] mat_store [64];
    logic [VAL_W-1:0] col_sums [8];
    logic [CFG_W-1:0] inner_reg = INNER_LEN_RST;
    logic [CFG_W-1:0] cols_reg = OUT_COLS_RST;
    dot_entry_t       pending_dots [$];

    int error_count = 0;
    int accepted_count = 0;
    int ignored_count = 0;
    int load_count = 0;
    int rows_emitted = 0;
    int results_seen = 0;
    int settings_used = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;

    function automatic logic [CFG_W-1:0] dim_in_use(input logic [CFG_W-1:0] v);
        if (v == 4'd0)
            return 4'd1;
        if (v > 4'd8)
            return 4'd8;
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        if (error_count < 30)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Applies one accepted transfer to the predictor and queues any row results.
    task automatic accumulate_item(input logic op, input logic [IDX_W-1:0] row,
                                   input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        logic [CFG_W-1:0] ni;
        logic [CFG_W-1:0] nc;
        dot_entry_t       e;
        ni = dim_in_use(inner_reg);
        nc = dim_in_use(cols_reg);
        if (op == OP_LOAD)
        begin
            mat_store[{row, col}] = val;
            load_count++;
            accepted_count++;
            return;
        end
        if ({1'b0, row} >= ni)
        begin
            ignored_count++;
            return;
        end
        accepted_count++;
        for (int c = 0; c < nc; c++)
            col_sums[c] = col_sums[c] + val * mat_store[{row, c[IDX_W-1:0]}];
        if ({1'b0, row} == ni - 4'd1)
        begin
            for (int c = 0; c < nc; c++)
            begin
                e.dot = col_sums[c];
                e.col = c[IDX_W-1:0];
                e.last = (c == nc - 1);
                pending_dots.push_back(e);
            end
            for (int c = 0; c < 8; c++)
                col_sums[c] = '0;
            rows_emitted++;
        end
    endtask

    // Leaves start high so the next transfer can follow back to back.
    task automatic send_item(input logic op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        start <= 1'b1;
        opcode <= op;
        row_index <= row;
        col_index <= col;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accumulate_item(op, row, col, val);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic pace();
        if (no_gaps)
            return;
        if (burst_left == 0)
        begin
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 10);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_paced(input logic op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        send_item(op, row, col, val);
        pace();
    endtask

    // Block idle: no results pending and no element still sweeping its columns.
    task automatic settle();
        idle_cycles(1);
        while (pending_dots.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] inner, input logic [CFG_W-1:0] cols);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_INNER_LEN;
        cfg_data <= inner;
        @(posedge clk);
        inner_reg = inner;
        cfg_index <= CFG_OUT_COLS;
        cfg_data <= cols;
        @(posedge clk);
        cols_reg = cols;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin : result_check
        dot_entry_t want;
        if (rst_n && result_strobe)
        begin
            results_seen++;
            if (pending_dots.size() == 0)
            begin
                report_mismatch("result with nothing pending", dot_value, '0);
            end
            else
            begin
                want = pending_dots.pop_front();
                if (dot_value !== want.dot)
                    report_mismatch("dot_value", dot_value, want.dot);
                if (out_col !== want.col)
                    report_mismatch("out_col", {29'd0, out_col}, {29'd0, want.col});
                if (last !== want.last)
                    report_mismatch("last", {31'd0, last}, {31'd0, want.last});
            end
        end
    end

    // Every store entry gets written before any stream reads it.
    task automatic test_fill_store();
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                send_paced(OP_LOAD, r[IDX_W-1:0], c[IDX_W-1:0], pick_value());
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 3'd0, 3'd0, 32'h8000_0000);
        send_item(OP_LOAD, 3'd0, 3'd1, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 3'd0, 3'd2, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 3'd7, 3'd7, 32'h8000_0000);
        // full 8x8 row at reset dimensions, extreme elements
        send_item(OP_STREAM, 3'd0, 3'd7, 32'h8000_0000);
        send_item(OP_STREAM, 3'd1, 3'd0, 32'h7FFF_FFFF);
        send_item(OP_STREAM, 3'd2, 3'd5, 32'hFFFF_FFFF);
        send_item(OP_STREAM, 3'd3, 3'd2, 32'h0000_0000);
        send_item(OP_STREAM, 3'd4, 3'd1, 32'h0000_0001);
        send_item(OP_STREAM, 3'd5, 3'd6, 32'h7FFF_FFFF);
        send_item(OP_STREAM, 3'd6, 3'd3, 32'h8000_0000);
        send_item(OP_STREAM, 3'd7, 3'd4, $urandom);
        // out-of-range position, repeated positions, load in mid row
        write_dims(4'd3, 4'd2);
        send_item(OP_STREAM, 3'd5, 3'd0, $urandom);
        send_item(OP_STREAM, 3'd1, 3'd0, 32'h8000_0000);
        send_item(OP_LOAD, 3'd1, 3'd1, 32'h7FFF_FFFF);
        send_item(OP_STREAM, 3'd1, 3'd7, 32'hFFFF_FFFF);
        send_item(OP_STREAM, 3'd0, 3'd0, $urandom);
        send_item(OP_STREAM, 3'd2, 3'd3, $urandom);
        // register values outside 1..8 clamp
        write_dims(4'd0, 4'd15);
        send_item(OP_STREAM, 3'd0, 3'd0, $urandom);
        send_item(OP_STREAM, 3'd7, 3'd0, $urandom);
        write_dims(4'd1, 4'd1);
        send_item(OP_STREAM, 3'd0, 3'd2, 32'h7FFF_FFFF);
        write_dims(4'd9, 4'd0);
        send_item(OP_STREAM, 3'd7, 3'd1, 32'h8000_0000);
        idle_cycles(1);
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] inner, input logic [CFG_W-1:0] cols,
                                input int target);
        int goal;
        int ni;
        int cut;
        write_dims(inner, cols);
        ni = dim_in_use(inner);
        goal = accepted_count + target;
        while (accepted_count < goal)
        begin
            case ($urandom_range(0, 9))
                7: send_paced(OP_LOAD, IDX_W'($urandom), IDX_W'($urandom), pick_value());
                8: send_paced(OP_STREAM, IDX_W'($urandom), IDX_W'($urandom), pick_value());
                9:
                begin
                    // broken row: leaves partial sums for the next row
                    cut = $urandom_range(0, ni - 1);
                    for (int p = 0; p < cut; p++)
                        send_paced(OP_STREAM, p[IDX_W-1:0], IDX_W'($urandom), pick_value());
                end
                default:
                begin
                    for (int p = 0; p < ni; p++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_paced(OP_LOAD, IDX_W'($urandom), IDX_W'($urandom),
                                       pick_value());
                        send_paced(OP_STREAM, p[IDX_W-1:0], IDX_W'($urandom), pick_value());
                    end
                end
            endcase
        end
        idle_cycles(1);
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] inner_set [4] = '{4'd8, 4'd1, 4'd1, 4'd8};
        logic [CFG_W-1:0] cols_set [4] = '{4'd8, 4'd1, 4'd8, 4'd1};
        for (int ph = 0; ph < 8; ph++)
        begin
            no_gaps = (ph % 4 == 2);
            if (ph < 4)
                random_phase(inner_set[ph], cols_set[ph], 28);
            else
                random_phase(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)), 28);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            col_sums[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_store();
        test_directed();
        test_random();
        settle();
        if (pending_dots.size() != 0)
            report_mismatch("results never arrived", pending_dots.size(), '0);
        $display("covered %0d accepted transfers (%0d loads), %0d ignored elements",
                 accepted_count, load_count, ignored_count);
        $display("checked %0d results from %0d rows over %0d register settings",
                 results_seen, rows_emitted, settings_used);
        if (error_count == 0)
            $display("row_times_matrix_mac_core verification clean");
        else
            $display("row_times_matrix_mac_core verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d results pending", pending_dots.size());
        $display("row_times_matrix_mac_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
